// ===== rtl/hswh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hswh_pkg;

    localparam int NUM_BUCKETS = 48;
    localparam int IDX_W       = $clog2(NUM_BUCKETS);
    localparam int CNT_W       = $clog2(NUM_BUCKETS + 1);
    localparam int INDEX_IN_W  = 6;
    localparam int CMP_W       = (IDX_W > INDEX_IN_W) ? IDX_W : INDEX_IN_W;

    localparam int BUCKET_W    = 8;
    localparam int SUM_W       = 14;
    localparam int HOUR_W      = 16;
    localparam int WORD_W      = 32;
    localparam int PCT_W       = 7;
    localparam int NUM_W       = WORD_W + PCT_W;
    localparam int DCNT_W      = $clog2(PCT_W + 1);
    localparam int PADDR_W     = 2;
    localparam int PDATA_W     = 32;

    localparam logic [BUCKET_W-1:0] BUCKET_MAX   = 8'd255;
    localparam logic [SUM_W-1:0]    SUM_MAX      = 14'h3FFF;
    localparam logic [HOUR_W-1:0]   DEFAULT_HOUR = 16'd3600;
    localparam logic [WORD_W-1:0]   WORD_MAX     = 32'hFFFF_FFFF;
    localparam logic [PCT_W-1:0]    PCT_SCALE    = 7'd100;

    localparam logic [PADDR_W-1:0]  ADDR_SECONDS_PER_HOUR = 2'd0;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_ATTEMPT,
        CMD_READ,
        CMD_CLEAR
    } cmd_code_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPLY,
        ST_INC_RD,
        ST_INC_WR,
        ST_SCAN,
        ST_MUL,
        ST_DIV,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic capture;
        logic apply;
        logic inc_read;
        logic inc_write;
        logic scan_init;
        logic scan_step;
        logic div_init;
        logic div_step;
        logic result_load;
    } dp_ctl_t;

    typedef struct packed {
        logic success_attempt;
        logic scan_done;
        logic div_done;
    } dp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/hswh_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hswh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 48
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/hswh_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hswh_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire hswh_pkg::dp_sts_t sts,
    output hswh_pkg::dp_ctl_t      ctl
);

    hswh_pkg::state_t state_reg;
    hswh_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hswh_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            hswh_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = hswh_pkg::ST_APPLY;
                end
            end
            hswh_pkg::ST_APPLY:
            begin
                ctl.apply     = 1'b1;
                ctl.scan_init = 1'b1;
                state_next    = sts.success_attempt ? hswh_pkg::ST_INC_RD : hswh_pkg::ST_SCAN;
            end
            hswh_pkg::ST_INC_RD:
            begin
                ctl.inc_read = 1'b1;
                state_next   = hswh_pkg::ST_INC_WR;
            end
            hswh_pkg::ST_INC_WR:
            begin
                ctl.inc_write = 1'b1;
                state_next    = hswh_pkg::ST_SCAN;
            end
            hswh_pkg::ST_SCAN:
            begin
                ctl.scan_step = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = hswh_pkg::ST_MUL;
                end
            end
            hswh_pkg::ST_MUL:
            begin
                ctl.div_init = 1'b1;
                state_next   = hswh_pkg::ST_DIV;
            end
            hswh_pkg::ST_DIV:
            begin
                ctl.div_step = 1'b1;
                if (sts.div_done)
                begin
                    state_next = hswh_pkg::ST_LOAD;
                end
            end
            hswh_pkg::ST_LOAD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    ctl.result_load = 1'b1;
                    state_next      = hswh_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hswh_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.result_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_load_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.result_load |-> (!out_valid_reg || out_ready))
        else $error("result loaded over an untaken word");

    a_inc_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hswh_pkg::ST_INC_WR) |-> ($past(state_reg) == hswh_pkg::ST_INC_RD))
        else $error("bucket write without a preceding read");

    a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == hswh_pkg::ST_LOAD))
        else $error("output valid raised outside the load state");

    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hswh_pkg::ST_DIV) |=>
            (state_reg == hswh_pkg::ST_DIV || state_reg == hswh_pkg::ST_LOAD))
        else $error("divider left to an unexpected state");
`endif

endmodule

`default_nettype wire

// ===== rtl/hswh_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hswh_dp (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire hswh_pkg::dp_ctl_t                   ctl,
    output hswh_pkg::dp_sts_t                        sts,
    input  wire logic [hswh_pkg::HOUR_W-1:0]         seconds_per_hour,
    input  wire logic [1:0]                          cmd,
    input  wire logic                                success,
    input  wire logic [hswh_pkg::INDEX_IN_W-1:0]     bucket_index,
    input  wire logic [hswh_pkg::WORD_W-1:0]         now_ms,
    output logic      [hswh_pkg::BUCKET_W-1:0]       bucket_value,
    output logic      [hswh_pkg::BUCKET_W-1:0]       peak_bucket,
    output logic      [hswh_pkg::SUM_W-1:0]          window_sum,
    output logic      [hswh_pkg::WORD_W-1:0]         total_successes,
    output logic      [hswh_pkg::WORD_W-1:0]         total_attempts,
    output logic      [hswh_pkg::WORD_W-1:0]         last_success_ms,
    output logic      [hswh_pkg::WORD_W-1:0]         last_attempt_ms,
    output logic      [hswh_pkg::PCT_W-1:0]          success_percent,
    output logic                                     hour_rolled
);

    // Captured input word.
    hswh_pkg::cmd_code_t                  cmd_reg;
    logic                                 success_reg;
    logic [hswh_pkg::INDEX_IN_W-1:0]      index_reg;
    logic [hswh_pkg::WORD_W-1:0]          now_reg;

    // Persistent state.
    logic [hswh_pkg::HOUR_W-1:0]          tick_reg, tick_next;
    logic [hswh_pkg::WORD_W-1:0]          succ_total_reg, succ_total_next;
    logic [hswh_pkg::WORD_W-1:0]          att_total_reg, att_total_next;
    logic [hswh_pkg::WORD_W-1:0]          last_succ_reg, last_succ_next;
    logic [hswh_pkg::WORD_W-1:0]          last_att_reg, last_att_next;
    logic [hswh_pkg::IDX_W-1:0]           head_reg, head_next;
    logic [hswh_pkg::NUM_BUCKETS-1:0]     valid_reg, valid_next;
    logic                                 rolled_reg, rolled_next;

    // Scan and divide.
    logic [hswh_pkg::CNT_W-1:0]           scan_cnt_reg, scan_cnt_next;
    logic                                 pend_reg, pend_next;
    logic [hswh_pkg::IDX_W-1:0]           pend_idx_reg;
    logic [hswh_pkg::BUCKET_W-1:0]        peak_reg, peak_next;
    logic [hswh_pkg::SUM_W-1:0]           sum_reg, sum_next;
    logic [hswh_pkg::BUCKET_W-1:0]        bval_reg, bval_next;
    logic [hswh_pkg::NUM_W-1:0]           rem_reg, rem_next;
    logic [hswh_pkg::NUM_W-1:0]           dsh_reg, dsh_next;
    logic [hswh_pkg::PCT_W-1:0]           quo_reg, quo_next;
    logic [hswh_pkg::DCNT_W-1:0]          dcnt_reg, dcnt_next;
    logic                                 rd_valid_reg;

    // Result word.
    logic [hswh_pkg::BUCKET_W-1:0]        bucket_value_reg;
    logic [hswh_pkg::BUCKET_W-1:0]        peak_bucket_reg;
    logic [hswh_pkg::SUM_W-1:0]           window_sum_reg;
    logic [hswh_pkg::WORD_W-1:0]          total_successes_reg;
    logic [hswh_pkg::WORD_W-1:0]          total_attempts_reg;
    logic [hswh_pkg::WORD_W-1:0]          last_success_ms_reg;
    logic [hswh_pkg::WORD_W-1:0]          last_attempt_ms_reg;
    logic [hswh_pkg::PCT_W-1:0]           success_percent_reg;
    logic                                 hour_rolled_reg;

    logic [hswh_pkg::IDX_W-1:0]           newest_addr;
    logic [hswh_pkg::IDX_W:0]             scan_sum;
    logic [hswh_pkg::IDX_W-1:0]           scan_addr;
    logic [hswh_pkg::IDX_W-1:0]           rd_addr;
    logic [hswh_pkg::BUCKET_W-1:0]        ram_q;
    logic [hswh_pkg::BUCKET_W-1:0]        rd_value;
    logic [hswh_pkg::BUCKET_W-1:0]        inc_value;
    logic                                 scan_issue;
    logic [hswh_pkg::HOUR_W:0]            tick_plus;
    logic [hswh_pkg::SUM_W:0]             sum_plus;
    logic [hswh_pkg::NUM_W-1:0]           product;
    logic [hswh_pkg::PCT_W-1:0]           pct_value;

    assign newest_addr = (head_reg == '0) ? hswh_pkg::IDX_W'(hswh_pkg::NUM_BUCKETS - 1)
                                          : head_reg - 1'b1;
    assign scan_sum    = (hswh_pkg::IDX_W + 1)'(head_reg)
                       + (hswh_pkg::IDX_W + 1)'(scan_cnt_reg[hswh_pkg::IDX_W-1:0]);
    assign scan_addr   = (scan_sum >= (hswh_pkg::IDX_W + 1)'(hswh_pkg::NUM_BUCKETS))
                       ? hswh_pkg::IDX_W'(scan_sum - (hswh_pkg::IDX_W + 1)'(hswh_pkg::NUM_BUCKETS))
                       : hswh_pkg::IDX_W'(scan_sum);
    assign rd_addr     = ctl.inc_read ? newest_addr : scan_addr;
    assign rd_value    = rd_valid_reg ? ram_q : '0;
    assign inc_value   = (rd_value == hswh_pkg::BUCKET_MAX) ? hswh_pkg::BUCKET_MAX
                                                           : rd_value + 1'b1;
    assign scan_issue  = ctl.scan_step && (scan_cnt_reg != hswh_pkg::CNT_W'(hswh_pkg::NUM_BUCKETS));
    assign tick_plus   = (hswh_pkg::HOUR_W + 1)'(tick_reg) + 1'b1;
    assign sum_plus    = (hswh_pkg::SUM_W + 1)'(sum_reg) + (hswh_pkg::SUM_W + 1)'(rd_value);
    assign product     = hswh_pkg::NUM_W'(succ_total_reg) * hswh_pkg::NUM_W'(hswh_pkg::PCT_SCALE);
    assign pct_value   = (att_total_reg == '0) ? '0
                       : ((quo_reg > hswh_pkg::PCT_SCALE) ? hswh_pkg::PCT_SCALE : quo_reg);

    hswh_ram #(
        .WIDTH (hswh_pkg::BUCKET_W),
        .DEPTH (hswh_pkg::NUM_BUCKETS)
    ) u_bucket_ram (
        .clk   (clk),
        .we    (ctl.inc_write),
        .waddr (newest_addr),
        .wdata (inc_value),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    always_comb
    begin
        tick_next       = tick_reg;
        succ_total_next = succ_total_reg;
        att_total_next  = att_total_reg;
        last_succ_next  = last_succ_reg;
        last_att_next   = last_att_reg;
        head_next       = head_reg;
        valid_next      = valid_reg;
        rolled_next     = rolled_reg;
        if (ctl.capture)
        begin
            rolled_next = 1'b0;
        end
        if (ctl.apply)
        begin
            case (cmd_reg)
                hswh_pkg::CMD_TICK:
                begin
                    if (tick_plus >= (hswh_pkg::HOUR_W + 1)'(seconds_per_hour))
                    begin
                        // The oldest entry is reused as the new current hour.
                        tick_next            = '0;
                        valid_next[head_reg] = 1'b0;
                        head_next            = (head_reg == hswh_pkg::IDX_W'(hswh_pkg::NUM_BUCKETS - 1))
                                             ? '0 : head_reg + 1'b1;
                        rolled_next          = 1'b1;
                    end
                    else
                    begin
                        tick_next = hswh_pkg::HOUR_W'(tick_plus);
                    end
                end
                hswh_pkg::CMD_ATTEMPT:
                begin
                    att_total_next = (att_total_reg == hswh_pkg::WORD_MAX)
                                   ? att_total_reg : att_total_reg + 1'b1;
                    last_att_next  = now_reg;
                    if (success_reg)
                    begin
                        succ_total_next = (succ_total_reg == hswh_pkg::WORD_MAX)
                                        ? succ_total_reg : succ_total_reg + 1'b1;
                        last_succ_next  = now_reg;
                    end
                end
                hswh_pkg::CMD_READ:
                begin
                    tick_next = tick_reg;
                end
                hswh_pkg::CMD_CLEAR:
                begin
                    tick_next       = '0;
                    succ_total_next = '0;
                    att_total_next  = '0;
                    last_succ_next  = '0;
                    last_att_next   = '0;
                    head_next       = '0;
                    valid_next      = '0;
                end
                default:
                begin
                    tick_next = tick_reg;
                end
            endcase
        end
        if (ctl.inc_write)
        begin
            valid_next[newest_addr] = 1'b1;
        end
    end

    always_comb
    begin
        scan_cnt_next = scan_cnt_reg;
        pend_next     = 1'b0;
        peak_next     = peak_reg;
        sum_next      = sum_reg;
        bval_next     = bval_reg;
        if (ctl.capture)
        begin
            bval_next = '0;
        end
        if (ctl.scan_init)
        begin
            scan_cnt_next = '0;
            peak_next     = '0;
            sum_next      = '0;
        end
        else
        begin
            if (scan_issue)
            begin
                scan_cnt_next = scan_cnt_reg + 1'b1;
                pend_next     = 1'b1;
            end
            if (pend_reg)
            begin
                if (rd_value > peak_reg)
                begin
                    peak_next = rd_value;
                end
                sum_next = (sum_plus > (hswh_pkg::SUM_W + 1)'(hswh_pkg::SUM_MAX))
                         ? hswh_pkg::SUM_MAX : hswh_pkg::SUM_W'(sum_plus);
                if (cmd_reg == hswh_pkg::CMD_READ
                    && hswh_pkg::CMP_W'(pend_idx_reg) == hswh_pkg::CMP_W'(index_reg))
                begin
                    bval_next = rd_value;
                end
            end
        end
    end

    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quo_next  = quo_reg;
        dcnt_next = dcnt_reg;
        if (ctl.div_init)
        begin
            rem_next  = product;
            dsh_next  = hswh_pkg::NUM_W'(att_total_reg) << (hswh_pkg::PCT_W - 1);
            quo_next  = '0;
            dcnt_next = '0;
        end
        else if (ctl.div_step && !sts.div_done)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_next = rem_reg - dsh_reg;
                quo_next = {quo_reg[hswh_pkg::PCT_W-2:0], 1'b1};
            end
            else
            begin
                quo_next = {quo_reg[hswh_pkg::PCT_W-2:0], 1'b0};
            end
            dsh_next  = dsh_reg >> 1;
            dcnt_next = dcnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg       <= '0;
            succ_total_reg <= '0;
            att_total_reg  <= '0;
            last_succ_reg  <= '0;
            last_att_reg   <= '0;
            head_reg       <= '0;
            valid_reg      <= '0;
            scan_cnt_reg   <= '0;
            pend_reg       <= 1'b0;
            dcnt_reg       <= '0;
        end
        else
        begin
            tick_reg       <= tick_next;
            succ_total_reg <= succ_total_next;
            att_total_reg  <= att_total_next;
            last_succ_reg  <= last_succ_next;
            last_att_reg   <= last_att_next;
            head_reg       <= head_next;
            valid_reg      <= valid_next;
            scan_cnt_reg   <= scan_cnt_next;
            pend_reg       <= pend_next;
            dcnt_reg       <= dcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg     <= hswh_pkg::cmd_code_t'(cmd);
            success_reg <= success;
            index_reg   <= bucket_index;
            now_reg     <= now_ms;
        end
        rolled_reg   <= rolled_next;
        pend_idx_reg <= scan_cnt_reg[hswh_pkg::IDX_W-1:0];
        rd_valid_reg <= valid_reg[rd_addr];
        peak_reg     <= peak_next;
        sum_reg      <= sum_next;
        bval_reg     <= bval_next;
        rem_reg      <= rem_next;
        dsh_reg      <= dsh_next;
        quo_reg      <= quo_next;
        if (ctl.result_load)
        begin
            bucket_value_reg    <= bval_reg;
            peak_bucket_reg     <= (peak_reg == '0) ? hswh_pkg::BUCKET_W'(1) : peak_reg;
            window_sum_reg      <= sum_reg;
            total_successes_reg <= succ_total_reg;
            total_attempts_reg  <= att_total_reg;
            last_success_ms_reg <= last_succ_reg;
            last_attempt_ms_reg <= last_att_reg;
            success_percent_reg <= pct_value;
            hour_rolled_reg     <= rolled_reg;
        end
    end

    assign sts.success_attempt = (cmd_reg == hswh_pkg::CMD_ATTEMPT) && success_reg;
    assign sts.scan_done       = (scan_cnt_reg == hswh_pkg::CNT_W'(hswh_pkg::NUM_BUCKETS)) && !pend_reg;
    assign sts.div_done        = (dcnt_reg == hswh_pkg::DCNT_W'(hswh_pkg::PCT_W));

    assign bucket_value    = bucket_value_reg;
    assign peak_bucket     = peak_bucket_reg;
    assign window_sum      = window_sum_reg;
    assign total_successes = total_successes_reg;
    assign total_attempts  = total_attempts_reg;
    assign last_success_ms = last_success_ms_reg;
    assign last_attempt_ms = last_attempt_ms_reg;
    assign success_percent = success_percent_reg;
    assign hour_rolled     = hour_rolled_reg;

endmodule

`default_nettype wire

// ===== rtl/hourly_success_window_histogram.sv =====
// Hourly success histogram: each input word is a tick, an attempt, a bucket read or a
// clear, and each produces exactly one result word with the peak bucket, window sum,
// saturating totals, last timestamps and success percentage. The buckets live in a
// single-port-read RAM addressed as a ring, so a window shift moves a head pointer and
// clears the valid bit of the reused bucket. Words are handled one at a time; a
// successful attempt also needs a read-modify-write of the current bucket. Each word
// passes through applying the command, the bucket scan (one RAM read per cycle), a
// 7-step restoring divider for the percentage and the result load. A finished word waits
// in the output register while the next word is taken. Register seconds_per_hour sits
// at address 0 and resets to 3600.
`timescale 1ns / 1ps
`default_nettype none

module hourly_success_window_histogram (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [hswh_pkg::PADDR_W-1:0]        paddr,
    input  wire logic [hswh_pkg::PDATA_W-1:0]        pwdata,
    output logic      [hswh_pkg::PDATA_W-1:0]        prdata,
    output logic                                     pready,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [1:0]                          cmd,
    input  wire logic                                success,
    input  wire logic [hswh_pkg::INDEX_IN_W-1:0]     bucket_index,
    input  wire logic [hswh_pkg::WORD_W-1:0]         now_ms,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic      [hswh_pkg::BUCKET_W-1:0]       bucket_value,
    output logic      [hswh_pkg::BUCKET_W-1:0]       peak_bucket,
    output logic      [hswh_pkg::SUM_W-1:0]          window_sum,
    output logic      [hswh_pkg::WORD_W-1:0]         total_successes,
    output logic      [hswh_pkg::WORD_W-1:0]         total_attempts,
    output logic      [hswh_pkg::WORD_W-1:0]         last_success_ms,
    output logic      [hswh_pkg::WORD_W-1:0]         last_attempt_ms,
    output logic      [hswh_pkg::PCT_W-1:0]          success_percent,
    output logic                                     hour_rolled
);

    logic [hswh_pkg::HOUR_W-1:0] sph_reg;
    logic [hswh_pkg::HOUR_W-1:0] sph_next;
    hswh_pkg::dp_ctl_t           dp_ctl;
    hswh_pkg::dp_sts_t           dp_sts;

    assign pready = 1'b1;

    always_comb
    begin
        sph_next = sph_reg;
        if (psel && penable && pwrite && pready && paddr == hswh_pkg::ADDR_SECONDS_PER_HOUR)
        begin
            sph_next = pwdata[hswh_pkg::HOUR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sph_reg <= hswh_pkg::DEFAULT_HOUR;
        end
        else
        begin
            sph_reg <= sph_next;
        end
    end

    assign prdata = (paddr == hswh_pkg::ADDR_SECONDS_PER_HOUR)
                  ? hswh_pkg::PDATA_W'(sph_reg) : '0;

    hswh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (dp_sts),
        .ctl       (dp_ctl)
    );

    hswh_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (dp_ctl),
        .sts              (dp_sts),
        .seconds_per_hour (sph_reg),
        .cmd              (cmd),
        .success          (success),
        .bucket_index     (bucket_index),
        .now_ms           (now_ms),
        .bucket_value     (bucket_value),
        .peak_bucket      (peak_bucket),
        .window_sum       (window_sum),
        .total_successes  (total_successes),
        .total_attempts   (total_attempts),
        .last_success_ms  (last_success_ms),
        .last_attempt_ms  (last_attempt_ms),
        .success_percent  (success_percent),
        .hour_rolled      (hour_rolled)
    );

endmodule

`default_nettype wire
